// ===== rtl/core/chb_pkg.sv =====
// Shared widths, latencies and types of the cubic Hermite coefficient solver.
`default_nettype none
package chb_pkg;
	localparam int InW    = 32;
	localparam int LimbW  = 32;
	localparam int MulAW  = 192;
	localparam int MulBW  = 34;
	localparam int Limbs  = MulAW / LimbW;
	localparam int PpW    = LimbW + MulBW;
	localparam int GapW   = 3 * LimbW - PpW;
	localparam int NumW   = 168;
	localparam int DenW   = 100;
	localparam int QuotB  = 66;
	localparam int CoefW  = 64;
	localparam int NCoef  = 4;
	localparam int MulLat = 5;
	localparam int NumLat = 21;
	localparam int DivLat = QuotB + 3;
	localparam int TotLat = NumLat + DivLat + 1;

	typedef struct packed {
		logic vld;
		logic zero;
		logic sat;
	} chb_div_st_t;
endpackage
`default_nettype wire

// ===== rtl/core/chb_mul.sv =====
// Pipelined wide by narrow signed multiplier built from limb partial products.
`default_nettype none
module chb_mul (
	input  wire logic                               clk,
	input  wire logic signed [chb_pkg::MulAW-1:0]   a,
	input  wire logic signed [chb_pkg::MulBW-1:0]   b,
	output logic signed [chb_pkg::MulAW-1:0]        p
);
	import chb_pkg::*;

	logic                 neg_s1, neg_s2, neg_s3, neg_s4;
	logic [MulAW-1:0]     am_s1;
	logic [MulBW-1:0]     bm_s1;
	logic [PpW-1:0]       pp_s2 [Limbs];
	logic [MulAW-1:0]     g0, g1, g2;
	logic [MulAW-1:0]     t_s3, g2_s3, sum_s4;
	logic signed [MulAW-1:0] p_s5;

	assign g0 = MulAW'({pp_s2[3], GapW'(0), pp_s2[0]});
	assign g1 = MulAW'({pp_s2[4], GapW'(0), pp_s2[1], LimbW'(0)});
	assign g2 = MulAW'({pp_s2[5], GapW'(0), pp_s2[2], (2 * LimbW)'(0)});

	always_ff @(posedge clk) begin
		neg_s1 <= a[MulAW-1] ^ b[MulBW-1];
		am_s1  <= a[MulAW-1] ? MulAW'(-a) : MulAW'(a);
		bm_s1  <= b[MulBW-1] ? MulBW'(-b) : MulBW'(b);
		for (int i = 0; i < Limbs; i++) begin
			pp_s2[i] <= PpW'(am_s1[LimbW*i +: LimbW]) * PpW'(bm_s1);
		end
		neg_s2 <= neg_s1;
		t_s3   <= g0 + g1;
		g2_s3  <= g2;
		neg_s3 <= neg_s2;
		sum_s4 <= t_s3 + g2_s3;
		neg_s4 <= neg_s3;
		p_s5   <= neg_s4 ? -$signed(sum_s4) : $signed(sum_s4);
	end

	assign p = p_s5;
endmodule
`default_nettype wire

// ===== rtl/core/chb_numer.sv =====
// Numerator and denominator pipeline of the Hermite coefficients over h cubed.
`default_nettype none
module chb_numer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              vld,
	input  wire logic signed [chb_pkg::InW-1:0]    x0,
	input  wire logic signed [chb_pkg::InW-1:0]    x1,
	input  wire logic signed [chb_pkg::InW-1:0]    v0,
	input  wire logic signed [chb_pkg::InW-1:0]    v1,
	input  wire logic signed [chb_pkg::InW-1:0]    s0,
	input  wire logic signed [chb_pkg::InW-1:0]    s1,
	output logic                                   vld_o,
	output logic                                   sing_o,
	output logic signed [chb_pkg::NumW-1:0]        n0,
	output logic signed [chb_pkg::NumW-1:0]        n1,
	output logic signed [chb_pkg::NumW-1:0]        n2,
	output logic signed [chb_pkg::NumW-1:0]        n3,
	output logic signed [chb_pkg::DenW-1:0]        den
);
	import chb_pkg::*;

	logic                    vld_p  [1:NumLat];
	logic                    sing_p [1:NumLat];
	logic signed [InW-1:0]   x0_p   [1:15];
	logic signed [InW-1:0]   v0_p   [1:9];
	logic signed [InW-1:0]   s0_p   [1:9];
	logic signed [InW:0]     h_s1, h_s2, h_s3, dv_s1, dv_s2;
	logic signed [InW+1:0]   sa_s1;
	logic signed [InW:0]     sb_s1;
	logic signed [66:0]      pa_s2;
	logic signed [65:0]      pb_s2, h2_s2, h2_s3;
	logic signed [67:0]      dvx, a_s3;
	logic signed [67:0]      b_p    [3:20];
	logic signed [MulAW-1:0] ah_s8, bx_s8, h3_s8, u_s9, bx_s9;
	logic signed [MulAW-1:0] w_s14, y_s14, h3s0_s14, h3v0_s14, dw_s15, z_s20;
	logic signed [DenW-1:0]  h3_p   [9:NumLat];
	logic signed [NumW-1:0]  n2_p   [10:NumLat];
	logic signed [NumW-1:0]  n1_p   [15:NumLat];
	logic signed [MulAW-1:0] hv_p   [15:20];
	logic signed [NumW-1:0]  n0_s21, n3_s21;

	assign dvx = 68'(dv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NumLat; k++) vld_p[k] <= 1'b0;
		end else begin
			vld_p[1] <= vld;
			for (int k = 2; k <= NumLat; k++) vld_p[k] <= vld_p[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sing_p[1] <= (x0 == x1);
		for (int k = 2; k <= NumLat; k++) sing_p[k] <= sing_p[k-1];
		x0_p[1] <= x0;
		for (int k = 2; k <= 15; k++) x0_p[k] <= x0_p[k-1];
		v0_p[1] <= v0;
		s0_p[1] <= s0;
		for (int k = 2; k <= 9; k++) begin
			v0_p[k] <= v0_p[k-1];
			s0_p[k] <= s0_p[k-1];
		end
		h_s1  <= 33'(x1) - 33'(x0);
		dv_s1 <= 33'(v1) - 33'(v0);
		sa_s1 <= 34'(s0) + 34'(s0) + 34'(s1);
		sb_s1 <= 33'(s0) + 33'(s1);
		pa_s2 <= 67'(h_s1) * 67'(sa_s1);
		pb_s2 <= 66'(h_s1) * 66'(sb_s1);
		h2_s2 <= 66'(h_s1) * 66'(h_s1);
		h_s2  <= h_s1;
		dv_s2 <= dv_s1;
		a_s3  <= (dvx <<< 17) + (dvx <<< 16) - 68'(pa_s2);
		b_p[3] <= 68'(pb_s2) - (dvx <<< 17);
		for (int k = 4; k <= 20; k++) b_p[k] <= b_p[k-1];
		h2_s3 <= h2_s2;
		h_s3  <= h_s2;
		u_s9  <= ah_s8 - bx_s8;
		bx_s9 <= bx_s8;
		h3_p[9] <= DenW'(h3_s8);
		for (int k = 10; k <= NumLat; k++) h3_p[k] <= h3_p[k-1];
		n2_p[10] <= NumW'(u_s9 - (bx_s9 <<< 1)) <<< 32;
		for (int k = 11; k <= NumLat; k++) n2_p[k] <= n2_p[k-1];
		n1_p[15] <= NumW'(h3s0_s14 - (w_s14 <<< 1) + y_s14) <<< 16;
		for (int k = 16; k <= NumLat; k++) n1_p[k] <= n1_p[k-1];
		dw_s15   <= w_s14 - h3s0_s14;
		hv_p[15] <= h3v0_s14;
		for (int k = 16; k <= 20; k++) hv_p[k] <= hv_p[k-1];
		n0_s21 <= NumW'((hv_p[20] <<< 16) + z_s20);
		n3_s21 <= NumW'(b_p[20]) <<< 48;
	end

	chb_mul u_mul_ah (.clk(clk), .a(MulAW'(a_s3)), .b(MulBW'(h_s3)), .p(ah_s8));
	chb_mul u_mul_bx (.clk(clk), .a(MulAW'(b_p[3])), .b(MulBW'(x0_p[3])), .p(bx_s8));
	chb_mul u_mul_h3 (.clk(clk), .a(MulAW'(h2_s3)), .b(MulBW'(h_s3)), .p(h3_s8));
	chb_mul u_mul_w  (.clk(clk), .a(u_s9), .b(MulBW'(x0_p[9])), .p(w_s14));
	chb_mul u_mul_y  (.clk(clk), .a(bx_s9), .b(MulBW'(x0_p[9])), .p(y_s14));
	chb_mul u_mul_hs (.clk(clk), .a(MulAW'(h3_p[9])), .b(MulBW'(s0_p[9])), .p(h3s0_s14));
	chb_mul u_mul_hv (.clk(clk), .a(MulAW'(h3_p[9])), .b(MulBW'(v0_p[9])), .p(h3v0_s14));
	chb_mul u_mul_z  (.clk(clk), .a(dw_s15), .b(MulBW'(x0_p[15])), .p(z_s20));

	assign vld_o  = vld_p[NumLat];
	assign sing_o = sing_p[NumLat];
	assign n0     = n0_s21;
	assign n1     = n1_p[NumLat];
	assign n2     = n2_p[NumLat];
	assign n3     = n3_s21;
	assign den    = h3_p[NumLat];
endmodule
`default_nettype wire

// ===== rtl/core/chb_div.sv =====
// Pipelined restoring divider with rounding to nearest and saturation to Q32.32.
`default_nettype none
module chb_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              vld,
	input  wire logic                              zero,
	input  wire logic signed [chb_pkg::NumW-1:0]   n,
	input  wire logic signed [chb_pkg::DenW-1:0]   d,
	output logic signed [chb_pkg::CoefW-1:0]       q,
	output chb_pkg::chb_div_st_t                   st
);
	import chb_pkg::*;

	localparam int TopW = NumW - QuotB + 1;

	logic                vld_s1, zero_s1, neg_s1;
	logic [NumW-1:0]     an_s1;
	logic [DenW-1:0]     ad_s1;
	logic [TopW-1:0]     top;
	logic                vld_p  [0:QuotB];
	logic                zero_p [0:QuotB];
	logic                neg_p  [0:QuotB];
	logic                sat_p  [0:QuotB];
	logic [DenW-1:0]     ad_p   [0:QuotB];
	logic [DenW-1:0]     rem_p  [0:QuotB];
	logic [QuotB-1:0]    low_p  [0:QuotB];
	logic [QuotB-1:0]    quo_p  [0:QuotB];
	logic [QuotB:0]      rsum;
	logic [QuotB-1:0]    qr;
	logic                sat_pos, sat_neg, sat_all;
	logic signed [CoefW-1:0] q_q;
	chb_div_st_t         st_q;

	assign top = an_s1[NumW-1:QuotB-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k <= QuotB; k++) vld_p[k] <= 1'b0;
			st_q <= '0;
		end else begin
			vld_s1   <= vld;
			vld_p[0] <= vld_s1;
			for (int k = 1; k <= QuotB; k++) vld_p[k] <= vld_p[k-1];
			st_q.vld  <= vld_p[QuotB];
			st_q.zero <= zero_p[QuotB];
			st_q.sat  <= !zero_p[QuotB] && sat_all;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1   <= zero;
		neg_s1    <= n[NumW-1] ^ d[DenW-1];
		an_s1     <= n[NumW-1] ? NumW'(-n) : NumW'(n);
		ad_s1     <= d[DenW-1] ? DenW'(-d) : DenW'(d);
		zero_p[0] <= zero_s1;
		neg_p[0]  <= neg_s1;
		sat_p[0]  <= (top >= TopW'(ad_s1));
		ad_p[0]   <= ad_s1;
		rem_p[0]  <= DenW'(top);
		low_p[0]  <= {an_s1[QuotB-2:0], 1'b0};
		quo_p[0]  <= '0;
	end

	for (genvar j = 1; j <= QuotB; j++) begin : g_step
		logic [DenW:0] trial;
		logic          ge;

		assign trial = {rem_p[j-1], low_p[j-1][QuotB-j]};
		assign ge    = (trial >= {1'b0, ad_p[j-1]});

		always_ff @(posedge clk) begin
			rem_p[j]  <= ge ? DenW'(trial - {1'b0, ad_p[j-1]}) : DenW'(trial);
			quo_p[j]  <= {quo_p[j-1][QuotB-2:0], ge};
			low_p[j]  <= low_p[j-1];
			ad_p[j]   <= ad_p[j-1];
			sat_p[j]  <= sat_p[j-1];
			neg_p[j]  <= neg_p[j-1];
			zero_p[j] <= zero_p[j-1];
		end
	end

	assign rsum    = {1'b0, quo_p[QuotB]} + (QuotB + 1)'(1);
	assign qr      = rsum[QuotB:1];
	assign sat_pos = |qr[QuotB-1:CoefW-1];
	assign sat_neg = (|qr[QuotB-1:CoefW]) || (qr[CoefW-1] && (|qr[CoefW-2:0]));
	assign sat_all = sat_p[QuotB] || (neg_p[QuotB] ? sat_neg : sat_pos);

	always_ff @(posedge clk) begin
		if (zero_p[QuotB]) begin
			q_q <= '0;
		end else if (sat_all) begin
			q_q <= neg_p[QuotB] ? {1'b1, (CoefW-1)'(0)} : {1'b0, {(CoefW-1){1'b1}}};
		end else begin
			q_q <= neg_p[QuotB] ? -$signed(qr[CoefW-1:0]) : $signed(qr[CoefW-1:0]);
		end
	end

	assign q  = q_q;
	assign st = st_q;
endmodule
`default_nettype wire

// ===== rtl/core/cubic_hermite_coefficient_solver.sv =====
// A transfer is accepted on every clock edge with start high; busy is always low, so a new
// ramp may enter in every cycle. Each result appears for one cycle with done high: multiplier
// stages form the numerators and h cubed, and the dividers then produce one quotient bit per
// stage, followed by the output register. The receiver cannot stall, and none is needed since
// nothing is held back.
`default_nettype none
module cubic_hermite_coefficient_solver (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [chb_pkg::InW-1:0]    start_position,
	input  wire logic signed [chb_pkg::InW-1:0]    end_position,
	input  wire logic signed [chb_pkg::InW-1:0]    start_value,
	input  wire logic signed [chb_pkg::InW-1:0]    end_value,
	input  wire logic signed [chb_pkg::InW-1:0]    start_slope,
	input  wire logic signed [chb_pkg::InW-1:0]    end_slope,
	output logic                                   done,
	output logic signed [chb_pkg::CoefW-1:0]       coef_constant,
	output logic signed [chb_pkg::CoefW-1:0]       coef_linear,
	output logic signed [chb_pkg::CoefW-1:0]       coef_square,
	output logic signed [chb_pkg::CoefW-1:0]       coef_cube,
	output logic                                   singular_flag,
	output logic                                   saturated_flag
);
	import chb_pkg::*;

	logic                    nvld, nsing;
	logic signed [NumW-1:0]  num [NCoef];
	logic signed [DenW-1:0]  den;
	logic signed [CoefW-1:0] quo [NCoef];
	chb_div_st_t             dst [NCoef];
	logic                    done_q, sing_q, sat_q;
	logic signed [CoefW-1:0] coef_q [NCoef];

	assign busy = 1'b0;

	chb_numer u_numer (
		.clk(clk), .arst_n(arst_n), .vld(start && !busy),
		.x0(start_position), .x1(end_position), .v0(start_value), .v1(end_value),
		.s0(start_slope), .s1(end_slope),
		.vld_o(nvld), .sing_o(nsing),
		.n0(num[0]), .n1(num[1]), .n2(num[2]), .n3(num[3]), .den(den)
	);

	for (genvar i = 0; i < NCoef; i++) begin : g_div
		chb_div u_div (
			.clk(clk), .arst_n(arst_n), .vld(nvld), .zero(nsing),
			.n(num[i]), .d(den), .q(quo[i]), .st(dst[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dst[0].vld;
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= dst[0].zero;
		sat_q  <= dst[0].sat | dst[1].sat | dst[2].sat | dst[3].sat;
		for (int i = 0; i < NCoef; i++) coef_q[i] <= quo[i];
	end

	assign done           = done_q;
	assign singular_flag  = sing_q;
	assign saturated_flag = sat_q;
	assign coef_constant  = coef_q[0];
	assign coef_linear    = coef_q[1];
	assign coef_square    = coef_q[2];
	assign coef_cube      = coef_q[3];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##TotLat done) else $error("result missing after a start transfer");
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TotLat)) else $error("result without a start transfer");
	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular_flag |-> !saturated_flag) else $error("singular result saturated");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular_flag |-> coef_constant == 0 && coef_linear == 0 &&
		coef_square == 0 && coef_cube == 0) else $error("singular result not zero");
endmodule
`default_nettype wire
